>>> hdl/rc6fps_pkg.sv
// Package for the RC6 infrared frame pulse sequencer.
// Holds payload widths, command and register codes, phase and result types.
// Used by the channel interfaces, the sequencer core and the top level.
package rc6fps_pkg;

  localparam int DATA_WIDTH_DEF = 64;

  localparam int FRAME_W  = 64;
  localparam int COUNT_W  = 7;
  localparam int REPEAT_W = 8;
  localparam int TICK_W   = 10;
  localparam int GAP_W    = 8;
  localparam int US_W     = 18;
  localparam int CFG_W    = 10;
  localparam int CFG_IDX_W = 1;

  localparam int HDR_MARK_TICKS   = 6;
  localparam int HDR_SPACE_TICKS  = 2;
  localparam int TRAILER_POSITION = 4;

  localparam logic [TICK_W-1:0] TICK_US_RESET   = TICK_W'(444);
  localparam logic [GAP_W-1:0]  GAP_TICKS_RESET = GAP_W'(187);

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK_US   = 1'b0,
    REG_GAP_TICKS = 1'b1
  } reg_index_t;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_HEADER = 5'b00010,
    PH_START  = 5'b00100,
    PH_DATA   = 5'b01000,
    PH_GAP    = 5'b10000
  } phase_t;

  typedef struct packed {
    logic            pair_valid;
    logic            mark_first;
    logic [US_W-1:0] first_us;
    logic [US_W-1:0] second_us;
    logic            frame_end;
    logic            sequence_end;
  } pair_t;

endpackage

>>> hdl/rc6fps_in_if.sv
// Input channel of the RC6 frame pulse sequencer: load and advance commands.
// Depends on rc6fps_pkg for the payload widths.
interface rc6fps_in_if;
  import rc6fps_pkg::*;

  logic                valid;
  logic                ready;
  logic                cmd;
  logic [FRAME_W-1:0]  frame_data;
  logic [COUNT_W-1:0]  bit_count;
  logic [REPEAT_W-1:0] repeat_count;

  modport source (output valid, cmd, frame_data, bit_count, repeat_count, input ready);
  modport sink   (input valid, cmd, frame_data, bit_count, repeat_count, output ready);
endinterface

>>> hdl/rc6fps_out_if.sv
// Output channel of the RC6 frame pulse sequencer: one mark/space pair per transfer.
// Depends on rc6fps_pkg for the payload widths.
interface rc6fps_out_if;
  import rc6fps_pkg::*;

  logic            valid;
  logic            ready;
  logic            pair_valid;
  logic            mark_first;
  logic [US_W-1:0] first_us;
  logic [US_W-1:0] second_us;
  logic            frame_end;
  logic            sequence_end;

  modport source (output valid, pair_valid, mark_first, first_us, second_us, frame_end,
                  sequence_end, input ready);
  modport sink   (input valid, pair_valid, mark_first, first_us, second_us, frame_end,
                  sequence_end, output ready);
endinterface

>>> hdl/rc6_ir_frame_pulse_sequencer.sv
// Top level of the RC6 infrared frame pulse sequencer.
// Depends on rc6fps_pkg, rc6fps_in_if, rc6fps_out_if and rc6fps_seq.
//
// Usage: a transfer on frame_in with cmd load stores a frame word, a bit
// count and a repeat count and restarts the sequence, or idles it if the
// bit count exceeds DATA_WIDTH; it returns nothing. Each transfer with cmd
// advance returns exactly one transfer on pair_out: the header pair, the
// start bit, the data bits most significant first and the gap pair that
// closes each repetition. Advancing while idle returns a pair with every
// field zero. The user must write the two timing registers through cfg_we,
// cfg_index and cfg_data only while no pair is outstanding; the block does
// not enforce this. One item is taken every cycle while pair_out does not stall.
// When pair_out stalls, frame_in stays ready only while the output register
// is empty or being drained in the same cycle, so one pair waits at most.
// Reset clears the sequence to idle, empties the output register and sets
// tick_us to 444 and gap_ticks to 187.
module rc6_ir_frame_pulse_sequencer #(
  parameter int DATA_WIDTH = rc6fps_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rc6fps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rc6fps_pkg::CFG_W-1:0]     cfg_data,
  rc6fps_in_if.sink                        frame_in,
  rc6fps_out_if.source                     pair_out
);
  import rc6fps_pkg::*;

  logic [TICK_W-1:0] tick_us;
  logic [GAP_W-1:0]  gap_ticks;
  logic              in_fire;
  logic              has_result;
  pair_t             result;
  pair_t             pair_reg;
  logic              out_valid;

  assign frame_in.ready = !out_valid || pair_out.ready;
  assign in_fire        = frame_in.valid && frame_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_us   <= TICK_US_RESET;
      gap_ticks <= GAP_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TICK_US:   tick_us   <= cfg_data[TICK_W-1:0];
        REG_GAP_TICKS: gap_ticks <= cfg_data[GAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rc6fps_seq #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .step         (in_fire),
    .cmd          (frame_in.cmd),
    .frame_data   (frame_in.frame_data),
    .bit_count    (frame_in.bit_count),
    .repeat_count (frame_in.repeat_count),
    .tick_us      (tick_us),
    .gap_ticks    (gap_ticks),
    .has_result   (has_result),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && has_result) begin
      out_valid <= 1'b1;
    end else if (pair_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && has_result) begin
      pair_reg <= result;
    end
  end

  assign pair_out.valid        = out_valid;
  assign pair_out.pair_valid   = pair_reg.pair_valid;
  assign pair_out.mark_first   = pair_reg.mark_first;
  assign pair_out.first_us     = pair_reg.first_us;
  assign pair_out.second_us    = pair_reg.second_us;
  assign pair_out.frame_end    = pair_reg.frame_end;
  assign pair_out.sequence_end = pair_reg.sequence_end;

endmodule

>>> hdl/rc6fps_seq.sv
// Sequencer core: frame state registers and the per-item pair computation.
// Depends on rc6fps_pkg; driven by the top level once per accepted transfer.
module rc6fps_seq #(
  parameter int DATA_WIDTH = rc6fps_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          cmd,
  input  logic [rc6fps_pkg::FRAME_W-1:0]  frame_data,
  input  logic [rc6fps_pkg::COUNT_W-1:0]  bit_count,
  input  logic [rc6fps_pkg::REPEAT_W-1:0] repeat_count,
  input  logic [rc6fps_pkg::TICK_W-1:0]   tick_us,
  input  logic [rc6fps_pkg::GAP_W-1:0]    gap_ticks,
  output logic                          has_result,
  output rc6fps_pkg::pair_t             result
);
  import rc6fps_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH + 1);
  localparam int IDX_W = $clog2(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] saved_frame, saved_frame_next;
  logic [CNT_W-1:0]      bits_left, bits_left_next;
  logic [CNT_W-1:0]      bit_position, bit_position_next;
  logic [REPEAT_W-1:0]   repeats_left, repeats_left_next;
  phase_t                frame_phase, frame_phase_next;

  logic [IDX_W-1:0] bit_index;
  logic [CNT_W-1:0] position_inc;
  logic [US_W-1:0]  tick_ext;
  logic [US_W-1:0]  half_us;

  always_comb begin
    bit_index    = IDX_W'(bits_left - CNT_W'(1));
    position_inc = bit_position + CNT_W'(1);
    tick_ext     = US_W'(tick_us);
    half_us      = (position_inc == CNT_W'(TRAILER_POSITION)) ? (tick_ext << 1) : tick_ext;
  end

  always_comb begin
    saved_frame_next  = saved_frame;
    bits_left_next    = bits_left;
    bit_position_next = bit_position;
    repeats_left_next = repeats_left;
    frame_phase_next  = frame_phase;
    has_result        = 1'b0;
    result            = '0;
    if (cmd == CMD_LOAD) begin
      if (bit_count > COUNT_W'(DATA_WIDTH)) begin
        frame_phase_next = PH_IDLE;
      end else begin
        saved_frame_next  = frame_data[DATA_WIDTH-1:0];
        bits_left_next    = CNT_W'(bit_count);
        bit_position_next = '0;
        repeats_left_next = repeat_count;
        frame_phase_next  = PH_HEADER;
      end
    end else begin
      has_result = 1'b1;
      case (frame_phase)
        PH_HEADER: begin
          result.pair_valid = 1'b1;
          result.mark_first = 1'b1;
          result.first_us   = tick_ext * US_W'(HDR_MARK_TICKS);
          result.second_us  = tick_ext * US_W'(HDR_SPACE_TICKS);
          frame_phase_next  = PH_START;
        end
        PH_START: begin
          result.pair_valid = 1'b1;
          result.mark_first = 1'b1;
          result.first_us   = tick_ext;
          result.second_us  = tick_ext;
          frame_phase_next  = (bits_left != '0) ? PH_DATA : PH_GAP;
        end
        PH_DATA: begin
          result.pair_valid = 1'b1;
          result.mark_first = saved_frame[bit_index];
          result.first_us   = half_us;
          result.second_us  = half_us;
          bit_position_next = position_inc;
          bits_left_next    = bits_left - CNT_W'(1);
          if (bits_left == CNT_W'(1)) begin
            frame_phase_next = PH_GAP;
          end
        end
        PH_GAP: begin
          result.pair_valid = 1'b1;
          result.first_us   = US_W'(gap_ticks) * tick_ext;
          result.frame_end  = 1'b1;
          if (repeats_left != '0) begin
            repeats_left_next = repeats_left - REPEAT_W'(1);
            bits_left_next    = bit_position;
            bit_position_next = '0;
            frame_phase_next  = PH_HEADER;
          end else begin
            result.sequence_end = 1'b1;
            frame_phase_next    = PH_IDLE;
          end
        end
        default: begin
          frame_phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      saved_frame  <= '0;
      bits_left    <= '0;
      bit_position <= '0;
      repeats_left <= '0;
      frame_phase  <= PH_IDLE;
    end else if (step) begin
      saved_frame  <= saved_frame_next;
      bits_left    <= bits_left_next;
      bit_position <= bit_position_next;
      repeats_left <= repeats_left_next;
      frame_phase  <= frame_phase_next;
    end
  end

endmodule
